FILE: rtl/cef_pkg.sv
// Shared constants, types and helpers for the cartoon edge/quantize filter.
`default_nettype none

package cef_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int STORED_ROWS  = 4;
   localparam int ROW_DEPTH    = STORED_ROWS * MAX_WIDTH + 8;
   localparam int ADDR_W       = $clog2(ROW_DEPTH);
   localparam int FW_W         = 11;
   localparam int FH_W         = 13;
   localparam int CH_W         = 8;
   localparam int NUM_CH       = 3;
   localparam int PIX_W        = NUM_CH * CH_W;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int MIN_SIZE     = 5;
   localparam int WIN_LAST     = 4;
   localparam int DIV_STEPS    = 8;
   localparam int DRAIN_CYCLES = 3;
   localparam int DIV10_MUL    = 6554;
   localparam int DIV10_SHIFT  = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_QUANT_LEVELS,
      REG_EDGE_THRESHOLD
   } csr_reg_type;

   typedef enum logic {
      FUNC_PIXEL,
      FUNC_FLUSH
   } func_type;

   // divider operand select: the step first, then one pass per channel
   localparam logic [1:0] DIV_SEL_STEP = 2'd0;
   localparam logic [1:0] DIV_SEL_LAST = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WIN,
      ST_DRAIN,
      ST_BLUR,
      ST_SQ,
      ST_EDGE,
      ST_DLOAD,
      ST_DITER,
      ST_OUT
   } cef_state_type;

   typedef struct packed {
      logic       accept;
      logic       clear;
      logic       tap_valid;
      logic [2:0] tap_row;
      logic [2:0] tap_col;
      logic       blur_fin;
      logic       sq;
      logic       edge_chk;
      logic       div_load;
      logic       div_iter;
      logic       div_last;
      logic [1:0] div_sel;
      logic       out_load;
   } cef_cmd_type;

   typedef struct packed {
      logic emit;
   } cef_status_type;

   // floor(x/10) for x <= 2550
   function automatic logic [CH_W-1:0] div10(input logic [11:0] x);
      logic [24:0] p;
      p = {13'd0, x} * 25'(DIV10_MUL);
      return p[DIV10_SHIFT +: CH_W];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/cef_ctrl.sv
// Sequencer for the cartoon filter: handshakes, window sweep, divider passes.
`default_nettype none

module cef_ctrl import cef_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire cef_status_type status,
   output cef_cmd_type         cmd
);

   cef_state_type state_ff, state_in;
   logic [2:0]    tap_row_ff, tap_row_in;
   logic [2:0]    tap_col_ff, tap_col_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [1:0]    sel_ff, sel_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_row_ff   <= '0;
         tap_col_ff   <= '0;
         cnt_ff       <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_row_ff   <= tap_row_in;
         tap_col_ff   <= tap_col_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      tap_row_in = tap_row_ff;
      tap_col_in = tap_col_ff;
      cnt_in     = cnt_ff;
      sel_in     = sel_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.emit) begin
                  cmd.clear  = 1'b1;
                  tap_row_in = '0;
                  tap_col_in = '0;
                  state_in   = ST_WIN;
               end
            end
         end
         ST_WIN: begin
            cmd.tap_valid = 1'b1;
            cmd.tap_row   = tap_row_ff;
            cmd.tap_col   = tap_col_ff;
            if (tap_col_ff == 3'(WIN_LAST)) begin
               tap_col_in = '0;
               if (tap_row_ff == 3'(WIN_LAST)) begin
                  cnt_in   = '0;
                  state_in = ST_DRAIN;
               end else begin
                  tap_row_in = tap_row_ff + 3'd1;
               end
            end else begin
               tap_col_in = tap_col_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == 3'(DRAIN_CYCLES - 1)) begin
               state_in = ST_BLUR;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_BLUR: begin
            cmd.blur_fin = 1'b1;
            state_in     = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq   = 1'b1;
            state_in = ST_EDGE;
         end
         ST_EDGE: begin
            cmd.edge_chk = 1'b1;
            sel_in       = DIV_SEL_STEP;
            state_in     = ST_DLOAD;
         end
         ST_DLOAD: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = sel_ff;
            cnt_in       = '0;
            state_in     = ST_DITER;
         end
         ST_DITER: begin
            cmd.div_iter = 1'b1;
            cmd.div_sel  = sel_ff;
            if (cnt_ff == 3'(DIV_STEPS - 1)) begin
               cmd.div_last = 1'b1;
               if (sel_ff == DIV_SEL_LAST) begin
                  state_in = ST_OUT;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = ST_DLOAD;
               end
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken item");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   a_quiet_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !status.emit) |=> (state_ff == ST_IDLE))
      else $error("item without result left the idle state");

   a_win_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WIN && tap_row_ff == 3'(WIN_LAST) && tap_col_ff == 3'(WIN_LAST))
      |=> (state_ff == ST_DRAIN))
      else $error("window sweep did not end in drain");

endmodule

`default_nettype wire

FILE: rtl/cef_datapath.sv
// Datapath: pixel store, window accumulators, edge test, quantizer, counters.
`default_nettype none

module cef_datapath import cef_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cef_cmd_type           cmd,
   output cef_status_type             status,
   input  wire logic                  req_func,
   input  wire logic [CH_W-1:0]       req_in_blue,
   input  wire logic [CH_W-1:0]       req_in_green,
   input  wire logic [CH_W-1:0]       req_in_red,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output logic [CH_W-1:0]            rsp_out_blue,
   output logic [CH_W-1:0]            rsp_out_green,
   output logic [CH_W-1:0]            rsp_out_red,
   output logic                       rsp_is_edge,
   output logic                       rsp_frame_last
);

   localparam int AS_W = ADDR_W + 2;

   // configuration
   logic [FW_W-1:0] fw_ff;
   logic [FH_W-1:0] fh_ff;
   logic [CH_W-1:0] ql_ff, thr_ff;
   logic [FW_W-1:0] cur_w;
   logic [FH_W-1:0] cur_h;
   logic [CH_W-1:0] levels;

   // positions
   logic [FW_W-1:0]   in_col_ff;
   logic [FH_W-1:0]   in_row_ff;
   logic [FW_W-1:0]   out_col_ff;
   logic [FH_W-1:0]   out_row_ff;
   logic [ADDR_W-1:0] wr_addr_ff, out_addr_ff;
   logic              done_ff;
   logic              restart, pix_wr, frame_last;

   logic [PIX_W-1:0]  store_mem [ROW_DEPTH];
   logic [PIX_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   // window pipeline
   logic       p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic [2:0] p1_row_ff, p1_col_ff, p2_row_ff, p3_row_ff;

   logic [11:0]       hrow_ff   [NUM_CH];
   logic [11:0]       hrow_in   [NUM_CH];
   logic signed [9:0] txrow_ff  [NUM_CH];
   logic signed [9:0] txrow_in  [NUM_CH];
   logic [9:0]        tyrow_ff  [NUM_CH];
   logic [9:0]        tyrow_in  [NUM_CH];
   logic [11:0]       rowsum_ff [NUM_CH];
   logic signed [9:0] txfin_ff  [NUM_CH];
   logic [9:0]        tyfin_ff  [NUM_CH];
   logic [CH_W-1:0]   hdiv_ff   [NUM_CH];
   logic signed [9:0] tx3_ff    [NUM_CH];
   logic [CH_W-1:0]   ty4_ff    [NUM_CH];
   logic [11:0]       vacc_ff   [NUM_CH];
   logic signed [10:0] gxacc_ff [NUM_CH];
   logic signed [9:0] gyacc_ff  [NUM_CH];

   logic [CH_W-1:0]    blur_ff [NUM_CH];
   logic signed [8:0]  gx_ff   [NUM_CH];
   logic signed [8:0]  gy_ff   [NUM_CH];
   logic signed [8:0]  gx_trunc[NUM_CH];
   logic [16:0]        mag_ff  [NUM_CH];
   logic [16:0]        thr_sq_ff;
   logic               edge_ff;
   logic [NUM_CH-1:0]  hit;
   logic               b_inside, s_inside;

   // shared restoring divider
   logic [CH_W-1:0] dvd_ff, dvs_ff, rem_ff, quo_ff;
   logic [CH_W-1:0] rem_in, quo_in;
   logic [CH_W:0]   trial;
   logic [CH_W-1:0] step_ff;
   logic [CH_W-1:0] qv_ff [NUM_CH];

   // ---------------- configuration and size limits
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff  <= FW_W'(640);
         fh_ff  <= FH_W'(480);
         ql_ff  <= CH_W'(8);
         thr_ff <= CH_W'(15);
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_FRAME_WIDTH:    fw_ff  <= csr_data[FW_W-1:0];
            REG_FRAME_HEIGHT:   fh_ff  <= csr_data[FH_W-1:0];
            REG_QUANT_LEVELS:   ql_ff  <= csr_data[CH_W-1:0];
            REG_EDGE_THRESHOLD: thr_ff <= csr_data[CH_W-1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      if (fw_ff < FW_W'(MIN_SIZE)) begin
         cur_w = FW_W'(MIN_SIZE);
      end else if (fw_ff > FW_W'(MAX_WIDTH)) begin
         cur_w = FW_W'(MAX_WIDTH);
      end else begin
         cur_w = fw_ff;
      end
      cur_h  = (fh_ff < FH_W'(MIN_SIZE)) ? FH_W'(MIN_SIZE) : fh_ff;
      levels = (ql_ff == '0) ? CH_W'(1) : ql_ff;
   end

   // ---------------- positions
   assign pix_wr = cmd.accept && (func_type'(req_func) == FUNC_PIXEL) && !done_ff;
   assign frame_last = (out_row_ff == cur_h - FH_W'(1)) && (out_col_ff == cur_w - FW_W'(1));
   assign restart = (csr_we && (csr_reg_type'(csr_index) == REG_FRAME_WIDTH ||
                                csr_reg_type'(csr_index) == REG_FRAME_HEIGHT)) ||
                    (cmd.out_load && frame_last);

   always_comb begin
      if (func_type'(req_func) == FUNC_FLUSH) begin
         status.emit = done_ff;
      end else begin
         status.emit = !done_ff && ((in_row_ff > FH_W'(2)) ||
                       (in_row_ff == FH_W'(2) && in_col_ff >= FW_W'(2)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         wr_addr_ff  <= '0;
         out_addr_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         if (pix_wr) begin
            wr_addr_ff <= (wr_addr_ff == ADDR_W'(ROW_DEPTH - 1)) ? '0 : wr_addr_ff + 1'b1;
            if (in_col_ff + FW_W'(1) >= cur_w) begin
               in_col_ff <= '0;
               if (in_row_ff + FH_W'(1) >= cur_h) begin
                  in_row_ff <= '0;
                  done_ff   <= 1'b1;
               end else begin
                  in_row_ff <= in_row_ff + FH_W'(1);
               end
            end else begin
               in_col_ff <= in_col_ff + FW_W'(1);
            end
         end
         if (cmd.out_load) begin
            out_addr_ff <= (out_addr_ff == ADDR_W'(ROW_DEPTH - 1)) ? '0 : out_addr_ff + 1'b1;
            if (out_col_ff + FW_W'(1) >= cur_w) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + FH_W'(1);
            end else begin
               out_col_ff <= out_col_ff + FW_W'(1);
            end
         end
      end
   end

   // ---------------- pixel store
   always_comb begin
      logic signed [AS_W-1:0] w_s, row_off, sum;
      w_s = $signed({{(AS_W-FW_W){1'b0}}, cur_w});
      case (cmd.tap_row)
         3'd0:    row_off = -(w_s <<< 1);
         3'd1:    row_off = -w_s;
         3'd3:    row_off = w_s;
         3'd4:    row_off = w_s <<< 1;
         default: row_off = '0;
      endcase
      sum = $signed({2'b00, out_addr_ff}) + row_off +
            $signed({{(AS_W-3){1'b0}}, cmd.tap_col}) - AS_W'(2);
      if (sum < 0) begin
         sum = sum + AS_W'(ROW_DEPTH);
      end else if (sum >= AS_W'(ROW_DEPTH)) begin
         sum = sum - AS_W'(ROW_DEPTH);
      end
      rd_addr = sum[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (pix_wr) begin
         store_mem[wr_addr_ff] <= {req_in_red, req_in_green, req_in_blue};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[rd_addr];
   end

   // ---------------- window accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cmd.tap_valid;
         p2_valid_ff <= p1_valid_ff && (p1_col_ff == 3'(WIN_LAST));
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_row_ff <= cmd.tap_row;
      p1_col_ff <= cmd.tap_col;
      p2_row_ff <= p1_row_ff;
      p3_row_ff <= p2_row_ff;
   end

   // per-row terms: blur [1 2 4 2 1], Sobel x [-1 0 1], Sobel y [1 2 1]
   always_comb begin
      logic [CH_W-1:0] p;
      logic [11:0]     hterm;
      logic signed [9:0] txterm;
      logic [9:0]      tyterm;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         p = rd_data_ff[CH_W*ch +: CH_W];
         case (p1_col_ff)
            3'd1, 3'd3: begin
               hterm  = {3'd0, p, 1'b0};
               tyterm = {2'd0, p};
            end
            3'd2: begin
               hterm  = {2'd0, p, 2'b00};
               tyterm = {1'b0, p, 1'b0};
            end
            default: begin
               hterm  = {4'd0, p};
               tyterm = '0;
            end
         endcase
         case (p1_col_ff)
            3'd1:    txterm = -$signed({2'b00, p});
            3'd3:    txterm = $signed({2'b00, p});
            default: txterm = '0;
         endcase
         if (p1_col_ff == 3'd0) begin
            hrow_in[ch]  = hterm;
            txrow_in[ch] = '0;
            tyrow_in[ch] = '0;
         end else begin
            hrow_in[ch]  = hrow_ff[ch] + hterm;
            txrow_in[ch] = txrow_ff[ch] + txterm;
            tyrow_in[ch] = tyrow_ff[ch] + tyterm;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (p1_valid_ff) begin
            hrow_ff[ch]  <= hrow_in[ch];
            txrow_ff[ch] <= txrow_in[ch];
            tyrow_ff[ch] <= tyrow_in[ch];
            rowsum_ff[ch] <= hrow_in[ch];
            txfin_ff[ch]  <= txrow_in[ch];
            tyfin_ff[ch]  <= tyrow_in[ch];
         end
         hdiv_ff[ch] <= div10(rowsum_ff[ch]);
         tx3_ff[ch]  <= txfin_ff[ch];
         ty4_ff[ch]  <= tyfin_ff[ch][9:2];
      end
   end

   // vertical pass over finished rows
   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (cmd.clear) begin
            vacc_ff[ch]  <= '0;
            gxacc_ff[ch] <= '0;
            gyacc_ff[ch] <= '0;
         end else if (p3_valid_ff) begin
            case (p3_row_ff)
               3'd1: begin
                  vacc_ff[ch]  <= vacc_ff[ch] + {3'd0, hdiv_ff[ch], 1'b0};
                  gxacc_ff[ch] <= gxacc_ff[ch] + 11'(tx3_ff[ch]);
                  gyacc_ff[ch] <= gyacc_ff[ch] + $signed({2'b00, ty4_ff[ch]});
               end
               3'd2: begin
                  vacc_ff[ch]  <= vacc_ff[ch] + {2'd0, hdiv_ff[ch], 2'b00};
                  gxacc_ff[ch] <= gxacc_ff[ch] + (11'(tx3_ff[ch]) <<< 1);
               end
               3'd3: begin
                  vacc_ff[ch]  <= vacc_ff[ch] + {3'd0, hdiv_ff[ch], 1'b0};
                  gxacc_ff[ch] <= gxacc_ff[ch] + 11'(tx3_ff[ch]);
                  gyacc_ff[ch] <= gyacc_ff[ch] - $signed({2'b00, ty4_ff[ch]});
               end
               default: begin
                  vacc_ff[ch] <= vacc_ff[ch] + {4'd0, hdiv_ff[ch]};
               end
            endcase
         end
      end
   end

   // ---------------- finish: borders, squares, edge test
   always_comb begin
      logic [10:0] mag_abs;
      logic [8:0]  q;
      b_inside = (out_row_ff >= FH_W'(2)) &&
                 ({1'b0, out_row_ff} + (FH_W+1)'(2) < {1'b0, cur_h}) &&
                 (out_col_ff >= FW_W'(2)) &&
                 ({1'b0, out_col_ff} + (FW_W+1)'(2) < {1'b0, cur_w});
      s_inside = (out_row_ff >= FH_W'(1)) &&
                 ({1'b0, out_row_ff} + (FH_W+1)'(1) < {1'b0, cur_h}) &&
                 (out_col_ff >= FW_W'(1)) &&
                 ({1'b0, out_col_ff} + (FW_W+1)'(1) < {1'b0, cur_w});
      for (int ch = 0; ch < NUM_CH; ch++) begin
         // divide by four, rounding toward zero
         mag_abs = gxacc_ff[ch][10] ? 11'(-gxacc_ff[ch]) : 11'(gxacc_ff[ch]);
         q = mag_abs[10:2];
         gx_trunc[ch] = gxacc_ff[ch][10] ? -$signed(q) : $signed(q);
      end
   end

   always_ff @(posedge clock) begin
      logic [CH_W:0] tp1;
      tp1 = {1'b0, thr_ff} + (CH_W+1)'(1);
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (cmd.blur_fin) begin
            blur_ff[ch] <= b_inside ? div10(vacc_ff[ch]) : '0;
            gx_ff[ch]   <= s_inside ? gx_trunc[ch] : '0;
            gy_ff[ch]   <= s_inside ? gyacc_ff[ch][8:0] : '0;
         end
         if (cmd.sq) begin
            mag_ff[ch] <= 17'(gx_ff[ch] * gx_ff[ch]) + 17'(gy_ff[ch] * gy_ff[ch]);
         end
      end
      if (cmd.sq) begin
         thr_sq_ff <= 17'(tp1 * tp1);
      end
      if (cmd.edge_chk) begin
         edge_ff <= |hit;
      end
   end

   // magnitude above threshold, with no square root: s > t iff v >= (t+1)^2
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         hit[ch] = (thr_ff != '1) && (mag_ff[ch] >= thr_sq_ff);
      end
   end

   // ---------------- quantizer: step = 255/levels, then v - v mod step
   always_comb begin
      trial = {rem_ff, dvd_ff[CH_W-1]};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = CH_W'(trial - {1'b0, dvs_ff});
         quo_in = {quo_ff[CH_W-2:0], 1'b1};
      end else begin
         rem_in = trial[CH_W-1:0];
         quo_in = {quo_ff[CH_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= '0;
         if (cmd.div_sel == DIV_SEL_STEP) begin
            dvd_ff <= '1;
            dvs_ff <= levels;
         end else begin
            dvd_ff <= blur_ff[cmd.div_sel - 2'd1];
            dvs_ff <= step_ff;
         end
      end else if (cmd.div_iter) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         dvd_ff <= {dvd_ff[CH_W-2:0], 1'b0};
         if (cmd.div_last) begin
            if (cmd.div_sel == DIV_SEL_STEP) begin
               step_ff <= quo_in;
            end else begin
               qv_ff[cmd.div_sel - 2'd1] <= blur_ff[cmd.div_sel - 2'd1] - rem_in;
            end
         end
      end
   end

   // ---------------- result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_out_blue   <= edge_ff ? '0 : qv_ff[0];
         rsp_out_green  <= edge_ff ? '0 : qv_ff[1];
         rsp_out_red    <= edge_ff ? '0 : qv_ff[2];
         rsp_is_edge    <= edge_ff;
         rsp_frame_last <= frame_last;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/cartoon_edge_quantize_filter.sv
// Cartoon filter top level: blur + quantize with Sobel edge darkening.
// Sequence: an item that yields a result is accepted, then the controller runs the
//   window sweep, drain, finish steps and divider passes before loading the result.
// Throughput: such an item holds off new input until its result is loaded, set by
//   the single-port window sweep and the shared bit-serial divider; other items are taken one per cycle while idle.
// Reset: synchronous, active high; registers return to 640x480, 8 levels,
//   threshold 15, all counters clear. The pixel store is not cleared.
`default_nettype none

module cartoon_edge_quantize_filter import cef_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input items
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_func,
   input  wire logic [CH_W-1:0]       req_in_blue,
   input  wire logic [CH_W-1:0]       req_in_green,
   input  wire logic [CH_W-1:0]       req_in_red,
   // result items
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [CH_W-1:0]            rsp_out_blue,
   output logic [CH_W-1:0]            rsp_out_green,
   output logic [CH_W-1:0]            rsp_out_red,
   output logic                       rsp_is_edge,
   output logic                       rsp_frame_last,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cef_cmd_type    cmd;
   cef_status_type status;
   logic           csr_we;

   // the user must change registers only while idle; the block does not enforce this, and writes are always taken
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // controller: handshakes, 5x5 sweep, drain, finish and divider steps
   cef_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: store, accumulators, edge test, quantizer, result register
   cef_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_func       (req_func),
      .req_in_blue    (req_in_blue),
      .req_in_green   (req_in_green),
      .req_in_red     (req_in_red),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_red    (rsp_out_red),
      .rsp_is_edge    (rsp_is_edge),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire
